// ----- src/pairwise_dissimilarity_assert.svh -----
// Assertion macros included by the top level to check the design.
`ifndef PAIRWISE_DISSIMILARITY_ASSERT_SVH
`define PAIRWISE_DISSIMILARITY_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pd_pkg.sv -----
package pd_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 1024;
  localparam int unsigned DEF_FRAC_BITS = 16;
  localparam int unsigned DIST_W = 48;
  localparam int unsigned Q_DEPTH = 4;

  localparam logic [3:0] M_EUCL = 4'd0;
  localparam logic [3:0] M_SQEUCL = 4'd1;
  localparam logic [3:0] M_CHORD = 4'd2;
  localparam logic [3:0] M_SQCHORD = 4'd3;
  localparam logic [3:0] M_BRAY = 4'd4;
  localparam logic [3:0] M_CHISQ = 4'd5;
  localparam logic [3:0] M_SQCHISQ = 4'd6;
  localparam logic [3:0] M_MANHATTAN = 4'd7;
  localparam logic [3:0] M_GOWER = 4'd8;
  localparam logic [3:0] M_ALTGOWER = 4'd9;

  typedef struct packed {
    logic [31:0] x_value;
    logic [31:0] y_value;
    logic        x_finite;
    logic        y_finite;
    logic        last;
  } pd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              missing;
  } pd_out_t;

  // One classified column pair as it waits between the front and the back.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] dev;
    logic [32:0] sum;
    logic        ok;
    logic        dz;
    logic        last;
    logic [3:0]  method;
  } pd_entry_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// ----- src/pd_front.sv -----
module pd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  pd_pkg::pd_in_t    item,
  output pd_pkg::pd_entry_t entry
);
  import pd_pkg::*;

  logic [3:0] method;

  always_ff @(posedge clk) begin
    if (rst) begin
      method <= M_EUCL;
    end else if (cfg_we) begin
      method <= cfg_wdata;
    end
  end

  always_comb begin
    entry.x = item.x_value;
    entry.y = item.y_value;
    entry.dev = (item.x_value >= item.y_value) ? item.x_value - item.y_value
                                               : item.y_value - item.x_value;
    entry.sum = {1'b0, item.x_value} + {1'b0, item.y_value};
    entry.ok = item.x_finite & item.y_finite;
    entry.dz = (item.x_value == 32'd0) && (item.y_value == 32'd0);
    entry.last = item.last;
    entry.method = method;
  end

endmodule

// ----- src/pd_queue.sv -----
module pd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pd_pkg::pd_entry_t din,
  input  logic              pop,
  output logic              empty,
  output pd_pkg::pd_entry_t dout
);
  import pd_pkg::*;

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  pd_entry_t       slots [Q_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full = (count == CW'(Q_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/pd_back.sv -----
module pd_back #(
  parameter int unsigned FRAC_BITS = pd_pkg::DEF_FRAC_BITS,
  parameter int unsigned MAX_COLUMNS = pd_pkg::DEF_MAX_COLUMNS
) (
  input  logic              clk,
  input  logic              rst,
  input  pd_pkg::pd_entry_t entry,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output pd_pkg::pd_out_t   result
);
  import pd_pkg::*;

  // Square root operand: the widest case is the sum shifted by FRAC_BITS + 1.
  localparam int unsigned SQ_W = 65 + FRAC_BITS + ((65 + FRAC_BITS) % 2);
  localparam int unsigned RT_W = SQ_W / 2;
  localparam int unsigned RM_W = RT_W + 2;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned CNTD_W = $clog2(MAX_COLUMNS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL = 4'd1;
  localparam logic [3:0] S_SQX = 4'd2;
  localparam logic [3:0] S_SQY = 4'd3;
  localparam logic [3:0] S_DIV = 4'd4;
  localparam logic [3:0] S_ACC = 4'd5;
  localparam logic [3:0] S_FIN = 4'd6;
  localparam logic [3:0] S_FSQ = 4'd7;
  localparam logic [3:0] S_FDIV = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic [3:0]        state;
  pd_entry_t         it;
  logic [31:0]       mul_op;
  logic [63:0]       prod;
  logic [63:0]       term;
  logic [63:0]       term_sum;
  logic [63:0]       total_sum;
  logic [CNTD_W-1:0] counted;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       rx;
  logic [63:0]       dist_val;
  logic              miss;
  logic              out_valid;
  pd_out_t           out_data;

  logic [SQ_W-1:0]   sq_op;
  logic [RT_W-1:0]   sq_root;
  logic [RM_W-1:0]   sq_rem;
  logic [RM_W-1:0]   sq_sh;
  logic [RM_W-1:0]   sq_trial;
  logic              sq_ge;
  logic [RM_W-1:0]   sq_rem_next;
  logic [RT_W-1:0]   sq_root_next;
  logic [31:0]       ry;

  logic [63:0]       div_r;
  logic [63:0]       div_n;
  logic [63:0]       div_q;
  logic [63:0]       div_den;
  logic [64:0]       div_sh;
  logic [64:0]       div_diff;
  logic              div_ge;
  logic [63:0]       div_r_next;
  logic [63:0]       div_q_next;

  logic              contribute;
  logic              is_chi;
  logic              can_out;

  // One bit of restoring square root per cycle.
  assign sq_sh = {sq_rem[RM_W-3:0], sq_op[SQ_W-1 -: 2]};
  assign sq_trial = {sq_root, 2'b01};
  assign sq_ge = (sq_sh >= sq_trial);
  assign sq_rem_next = sq_ge ? sq_sh - sq_trial : sq_sh;
  assign sq_root_next = {sq_root[RT_W-2:0], sq_ge};
  assign ry = sq_root_next[31:0];

  // One quotient bit of restoring division per cycle.
  assign div_sh = {div_r, div_n[63]};
  assign div_diff = div_sh - {1'b0, div_den};
  assign div_ge = (div_sh >= {1'b0, div_den});
  assign div_r_next = div_ge ? div_diff[63:0] : div_sh[63:0];
  assign div_q_next = {div_q[62:0], div_ge};

  assign prod = {32'd0, mul_op} * {32'd0, mul_op};

  assign is_chi = (entry.method == M_CHISQ) || (entry.method == M_SQCHISQ);
  assign contribute = entry.ok && (entry.method <= M_ALTGOWER) && !(is_chi && entry.dz);
  assign q_pop = (state == S_IDLE) && !q_empty;
  assign can_out = !out_valid || pop;

  assign empty = !out_valid;
  assign result = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term_sum <= '0;
      total_sum <= '0;
      counted <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && can_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            it <= entry;
            if (!contribute) begin
              state <= entry.last ? S_FIN : S_IDLE;
            end else if ((entry.method == M_EUCL) || (entry.method == M_SQEUCL) || is_chi) begin
              mul_op <= entry.dev;
              state <= S_MUL;
            end else if ((entry.method == M_CHORD) || (entry.method == M_SQCHORD)) begin
              sq_op <= SQ_W'({entry.x, {FRAC_BITS{1'b0}}});
              sq_root <= '0;
              sq_rem <= '0;
              cnt <= CNT_W'(RT_W - 1);
              state <= S_SQX;
            end else begin
              term <= {32'd0, entry.dev};
              state <= S_ACC;
            end
          end
        end
        S_MUL: begin
          term <= prod;
          div_r <= '0;
          div_n <= prod;
          div_q <= '0;
          div_den <= {31'd0, it.sum};
          cnt <= CNT_W'(63);
          state <= ((it.method == M_CHISQ) || (it.method == M_SQCHISQ)) ? S_DIV : S_ACC;
        end
        S_SQX: begin
          if (cnt == '0) begin
            rx <= sq_root_next[31:0];
            sq_op <= SQ_W'({it.y, {FRAC_BITS{1'b0}}});
            sq_root <= '0;
            sq_rem <= '0;
            cnt <= CNT_W'(RT_W - 1);
            state <= S_SQY;
          end else begin
            sq_op <= sq_op << 2;
            sq_rem <= sq_rem_next;
            sq_root <= sq_root_next;
            cnt <= cnt - 1'b1;
          end
        end
        S_SQY: begin
          sq_op <= sq_op << 2;
          sq_rem <= sq_rem_next;
          sq_root <= sq_root_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            mul_op <= (rx >= ry) ? rx - ry : ry - rx;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          div_r <= div_r_next;
          div_n <= div_n << 1;
          div_q <= div_q_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            term <= div_q_next;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          term_sum <= sat_add64(term_sum, term);
          if (it.method == M_BRAY) begin
            total_sum <= sat_add64(total_sum, {31'd0, it.sum});
          end
          if (counted != CNTD_W'(MAX_COLUMNS)) begin
            counted <= counted + 1'b1;
          end
          state <= it.last ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          sq_root <= '0;
          sq_rem <= '0;
          if ((counted == '0) || (it.method > M_ALTGOWER)) begin
            miss <= 1'b1;
            state <= S_OUT;
          end else if ((it.method == M_EUCL) || (it.method == M_CHORD)) begin
            miss <= 1'b0;
            sq_op <= SQ_W'(term_sum);
            cnt <= CNT_W'(RT_W - 1);
            state <= S_FSQ;
          end else if ((it.method == M_SQEUCL) || (it.method == M_SQCHORD)) begin
            miss <= 1'b0;
            dist_val <= term_sum >> FRAC_BITS;
            state <= S_OUT;
          end else if (it.method == M_BRAY) begin
            if (total_sum == '0) begin
              miss <= 1'b1;
              state <= S_OUT;
            end else if (term_sum >= total_sum) begin
              miss <= 1'b0;
              dist_val <= 64'd1 << FRAC_BITS;
              state <= S_OUT;
            end else begin
              miss <= 1'b0;
              div_r <= term_sum;
              div_n <= '0;
              div_q <= '0;
              div_den <= total_sum;
              cnt <= CNT_W'(FRAC_BITS - 1);
              state <= S_FDIV;
            end
          end else if (it.method == M_CHISQ) begin
            miss <= 1'b0;
            sq_op <= SQ_W'({term_sum, {FRAC_BITS{1'b0}}});
            cnt <= CNT_W'(RT_W - 1);
            state <= S_FSQ;
          end else if (it.method == M_ALTGOWER) begin
            miss <= 1'b0;
            sq_op <= SQ_W'({term_sum, {(FRAC_BITS + 1){1'b0}}});
            cnt <= CNT_W'(RT_W - 1);
            state <= S_FSQ;
          end else begin
            miss <= 1'b0;
            dist_val <= term_sum;
            state <= S_OUT;
          end
        end
        S_FSQ: begin
          sq_op <= sq_op << 2;
          sq_rem <= sq_rem_next;
          sq_root <= sq_root_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            dist_val <= 64'(sq_root_next);
            state <= S_OUT;
          end
        end
        S_FDIV: begin
          div_r <= div_r_next;
          div_n <= div_n << 1;
          div_q <= div_q_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            dist_val <= div_q_next;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (can_out) begin
            out_data.missing <= miss;
            if (miss) begin
              out_data.distance <= '0;
            end else if (|dist_val[63:DIST_W]) begin
              out_data.distance <= '1;
            end else begin
              out_data.distance <= dist_val[DIST_W-1:0];
            end
            term_sum <= '0;
            total_sum <= '0;
            counted <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/pairwise_dissimilarity.sv -----
// Channel   Direction  Handshake           Payload
// item      in         push / full         pd_in_t: x_value, y_value, flags, last
// result    out        pop / empty         pd_out_t: distance, missing
// config    in         cfg_we              cfg_wdata: method code
//
// Each column pair is registered into the queue, then passes in the back end through S_ACC
// (plain term), S_MUL and S_ACC (multiply), S_MUL, the bit-serial divider S_DIV and S_ACC
// (chi-square), or the roots S_SQX and S_SQY, then S_MUL and S_ACC (chord). The last pair adds
// S_FIN and S_OUT, with a final root in S_FSQ or the Bray-Curtis division in S_FDIV between.
// Reset is synchronous and clears the queue, the sums and the method register.
// A held result stalls only the back end; the queue of four keeps taking items until it fills.
module pairwise_dissimilarity #(
  parameter int unsigned FRAC_BITS = pd_pkg::DEF_FRAC_BITS,
  parameter int unsigned MAX_COLUMNS = pd_pkg::DEF_MAX_COLUMNS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  pd_pkg::pd_in_t  item,
  output logic            empty,
  input  logic            pop,
  output pd_pkg::pd_out_t result,
  input  logic            cfg_we,
  input  logic [3:0]      cfg_wdata
);
  import pd_pkg::*;

  pd_entry_t front_entry;
  pd_entry_t q_entry;
  logic      q_empty;
  logic      q_pop;

  pd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .entry     (front_entry)
  );

  pd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (front_entry),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_entry)
  );

  pd_back #(
    .FRAC_BITS   (FRAC_BITS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .entry   (q_entry),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

`include "pairwise_dissimilarity_assert.svh"

  `PD_ASSERT_IMP(a_missing_zero, !empty && result.missing, result.distance == '0,
                 "missing result carries a nonzero distance")
  `PD_ASSERT_IMP(a_take_nonempty, q_pop, !q_empty,
                 "back end took an entry from an empty queue")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import pd_pkg::*;

  localparam int unsigned FRAC = DEF_FRAC_BITS;
  localparam int unsigned COL_LIMIT = DEF_MAX_COLUMNS;
  localparam logic [63:0] DIST_CEIL = (64'd1 << DIST_W) - 64'd1;
  localparam int TAIL_CYCLES = 300;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  pd_in_t  item = '0;
  logic    empty;
  logic    pop = 1'b0;
  pd_out_t result;
  logic    cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;

  pairwise_dissimilarity DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow of the accumulator state.
  logic [3:0]  acc_method = M_EUCL;
  logic [63:0] acc_terms = '0;
  logic [63:0] acc_total = '0;
  int unsigned acc_count = 0;
  pd_out_t     dist_q[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int sent = 0;
  int mismatches = 0;
  pd_out_t want;

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'b0, cand} * {64'b0, cand} <= v) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  task automatic predict_pair(input pd_in_t it);
    logic [63:0] dx, dy, dev, term, rx, ry, d, dval;
    logic [79:0] q;
    bit count_it, miss;
    dx = {32'b0, it.x_value};
    dy = {32'b0, it.y_value};
    dev = (dx >= dy) ? dx - dy : dy - dx;
    if (it.x_finite && it.y_finite && acc_method <= M_ALTGOWER) begin
      count_it = 1;
      term = '0;
      case (acc_method)
        M_EUCL, M_SQEUCL: term = dev * dev;
        M_CHORD, M_SQCHORD: begin
          rx = isqrt({64'b0, dx} << FRAC);
          ry = isqrt({64'b0, dy} << FRAC);
          d = (rx >= ry) ? rx - ry : ry - rx;
          term = d * d;
        end
        M_BRAY: begin
          term = dev;
          acc_total = add_sat(acc_total, dx + dy);
        end
        M_CHISQ, M_SQCHISQ: begin
          // A double zero is left out of the row altogether.
          if (dx == 0 && dy == 0) count_it = 0;
          else term = (dev * dev) / (dx + dy);
        end
        default: term = dev;
      endcase
      if (count_it) begin
        acc_terms = add_sat(acc_terms, term);
        if (acc_count < COL_LIMIT) acc_count++;
      end
    end
    if (!it.last) return;
    miss = 0;
    dval = '0;
    if (acc_count == 0 || acc_method > M_ALTGOWER) begin
      miss = 1;
    end else begin
      case (acc_method)
        M_EUCL, M_CHORD: dval = isqrt({64'b0, acc_terms});
        M_SQEUCL, M_SQCHORD: dval = acc_terms >> FRAC;
        M_BRAY: begin
          if (acc_total == 0) begin
            miss = 1;
          end else if (acc_terms >= acc_total) begin
            dval = 64'd1 << FRAC;
          end else begin
            q = {acc_terms, 16'b0} / {16'b0, acc_total};
            dval = q[63:0];
          end
        end
        M_CHISQ: dval = isqrt({64'b0, acc_terms} << FRAC);
        M_ALTGOWER: dval = isqrt({64'b0, acc_terms} << (FRAC + 1));
        default: dval = acc_terms;
      endcase
    end
    if (miss) dval = '0;
    if (dval > DIST_CEIL) dval = DIST_CEIL;
    dist_q.push_back('{distance: dval[DIST_W-1:0], missing: miss});
    acc_terms = '0;
    acc_total = '0;
    acc_count = 0;
  endtask

  // Drives one column pair and returns once the block has taken it.
  task automatic send_pair(input logic [31:0] x, input logic [31:0] y,
                           input bit xf, input bit yf, input bit lst);
    while ($urandom_range(99) < idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    item = '{x_value: x, y_value: y, x_finite: xf, y_finite: yf, last: lst};
    do @(posedge clk); while (full);
    predict_pair(item);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    push = 1'b0;
    while (dist_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_method(input logic [3:0] m);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    acc_method = m;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h3_0000);
      3: return 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_row(input int len);
    for (int i = 0; i < len; i++)
      send_pair(pick_value(), pick_value(), $urandom_range(99) < 92,
                $urandom_range(99) < 92, i == len - 1);
  endtask

  task automatic test_methods_directed();
    for (int m = M_EUCL; m <= M_ALTGOWER; m++) begin
      set_method(m[3:0]);
      send_pair(32'hFFFF_FFFF, 32'h0, 1, 1, 0);
      send_pair(32'h0, 32'h0, 1, 1, 1);
    end
    // A row where every pair has a non-finite side gives a missing result.
    set_method(M_EUCL);
    send_pair(32'h1234_5678, 32'h1, 0, 1, 0);
    send_pair(32'h1, 32'h8765_4321, 1, 0, 1);
    // Bray-Curtis with an all-zero row has a zero total.
    set_method(M_BRAY);
    send_pair(32'h0, 32'h0, 1, 1, 1);
  endtask

  task automatic test_unknown_methods();
    for (int m = M_ALTGOWER + 1; m < 16; m++) begin
      set_method(m[3:0]);
      send_row(3);
    end
  endtask

  task automatic test_long_row();
    // More columns than the count holds, with terms large enough to saturate.
    set_method(M_SQEUCL);
    for (int i = 0; i < COL_LIMIT + 6; i++)
      send_pair(32'hFFFF_FFFF, 32'h0, 1, 1, i == COL_LIMIT + 5);
  endtask

  task automatic test_backpressure();
    set_method(M_MANHATTAN);
    idle_pct = 0;
    hold_req = 600;
    repeat (20) send_row(3);
  endtask

  task automatic test_random_rows();
    int quota;
    quota = 1700;
    for (int ph = 0; sent < quota; ph = (ph + 1) % 4) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      set_method(($urandom_range(99) < 88) ? 4'($urandom_range(M_ALTGOWER))
                                           : 4'($urandom_range(15, M_ALTGOWER + 1)));
      repeat (12) send_row(($urandom_range(9) == 0) ? 20 : $urandom_range(1, 6));
    end
  endtask

  always @(negedge clk) begin
    if (rst) begin
      pop = 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      pop = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop = 1'b0;
    end else begin
      pop = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (dist_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected transfer: distance %h missing %b", result.distance,
                   result.missing);
      end else begin
        want = dist_q.pop_front();
        if (result.distance !== want.distance || result.missing !== want.missing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected distance %h missing %b, got %h %b",
                     want.distance, want.missing, result.distance, result.missing);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_methods_directed();
    test_unknown_methods();
    test_long_row();
    test_backpressure();
    test_random_rows();
    wait_idle();
    if (mismatches == 0 && dist_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
